[src/cubic_four_point_curve_sampler_assert.svh]
// Assertion macros for the RTL. Simulation gets the checks, synthesis gets nothing.
`ifndef CUBIC_FOUR_POINT_CURVE_SAMPLER_ASSERT_SVH
`define CUBIC_FOUR_POINT_CURVE_SAMPLER_ASSERT_SVH

`ifndef SYNTHESIS

`define CFPS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define CFPS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CFPS_ASSERT_IMPL(name, clk, rst_n, ante, cons)

`define CFPS_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[src/cfps_pkg.sv]
`default_nettype none

package cfps_pkg;

    localparam int SAMPLES    = 100;
    localparam int COORD_BITS = 16;
    localparam int IDX_BITS   = 7;
    localparam int LAST_IDX   = SAMPLES - 1;
    localparam int NUM_STAGES = 7;

    localparam int NUM_REGS     = 8;
    localparam int CFG_IDX_BITS = 4;

    localparam longint DEN      = 2 * longint'(LAST_IDX) * longint'(LAST_IDX)
                                    * longint'(LAST_IDX);
    localparam longint HALF_DEN = DEN / 2;
    localparam int     DEN_BITS = $clog2(DEN);

    localparam int W_BITS    = DEN_BITS + 2;
    localparam int PROD_BITS = COORD_BITS + W_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;

    localparam longint SAT_LIM = (longint'(1) << (COORD_BITS - 1)) * DEN;

    localparam int U_BITS   = COORD_BITS + DEN_BITS;
    localparam int SH       = DEN_BITS - 4;
    localparam int HI_BITS  = U_BITS - SH;
    localparam int M_BITS   = HI_BITS - 2;
    localparam int QP_BITS  = HI_BITS + M_BITS;
    localparam int REM_BITS = DEN_BITS + 2;

    localparam longint RECIP = (longint'(1) << (SH + HI_BITS)) / DEN;

    typedef logic signed [COORD_BITS-1:0]     t_coord;
    typedef logic [3:0][COORD_BITS-1:0]       t_coord4;
    typedef logic [3:0][W_BITS-1:0]           t_wvec;
    typedef logic [SAMPLES-1:0][3:0][W_BITS-1:0] t_wtab;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_P1_X = 4'd0,
        REG_P1_Y = 4'd1,
        REG_P2_X = 4'd2,
        REG_P2_Y = 4'd3,
        REG_P3_X = 4'd4,
        REG_P3_Y = 4'd5,
        REG_P4_X = 4'd6,
        REG_P4_Y = 4'd7
    } t_cfg_reg;

    localparam t_coord RST_P1_X = -16'sd16384;
    localparam t_coord RST_P1_Y = 16'sd0;
    localparam t_coord RST_P2_X = -16'sd8192;
    localparam t_coord RST_P2_Y = 16'sd16384;
    localparam t_coord RST_P3_X = 16'sd8192;
    localparam t_coord RST_P3_Y = 16'sd16384;
    localparam t_coord RST_P4_X = 16'sd16384;
    localparam t_coord RST_P4_Y = 16'sd0;

    // Lagrange weights scaled by 2*D^3, one row per sample index.
    function automatic t_wtab f_build_weights();
        t_wtab  tab;
        longint d;
        longint nn;
        longint b;
        longint c;
        longint m;
        tab = '0;
        d   = longint'(LAST_IDX);
        for (int n = 0; n < SAMPLES; n++) begin
            nn = longint'(n);
            b  = 3 * nn - d;
            c  = 3 * nn - 2 * d;
            m  = d - nn;
            tab[n][0] = W_BITS'(b * c * m);
            tab[n][1] = W_BITS'(-9 * nn * c * m);
            tab[n][2] = W_BITS'(9 * nn * b * m);
            tab[n][3] = W_BITS'(nn * b * c);
        end
        return tab;
    endfunction

    localparam t_wtab W_TAB = f_build_weights();

endpackage

`default_nettype wire

[src/cubic_four_point_curve_sampler.sv]
`default_nettype none
// Samples the cubic curve through four configured Q1.15 points placed at t = -1, 0, 1
// and 2, with t = -1 + 3*index/(SAMPLES-1); indexes past the last sample read as the
// last one. One request is accepted every clock unless o_stall is high, and each
// passes through the weight lookup, multiply, sum, saturate and constant-divide
// pipeline. Results round to nearest with ties upward and saturate to 16 bits.
// Back-pressure on the output only holds stages that carry a valid request, so empty
// stages keep filling. Control-point registers are written through the configuration
// port, which is always ready, and should only change while the pipeline is empty.

`include "cubic_four_point_curve_sampler_assert.svh"

module cubic_four_point_curve_sampler (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [cfps_pkg::IDX_BITS-1:0]      i_sample_index,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [cfps_pkg::COORD_BITS-1:0]  o_point_x,
    output logic signed [cfps_pkg::COORD_BITS-1:0]  o_point_y,
    output logic                                    o_is_last,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [cfps_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [cfps_pkg::COORD_BITS-1:0]    i_cfg_data
);
    import cfps_pkg::*;

    t_coord r_p1_x;
    t_coord r_p1_y;
    t_coord r_p2_x;
    t_coord r_p2_y;
    t_coord r_p3_x;
    t_coord r_p3_y;
    t_coord r_p4_x;
    t_coord r_p4_y;

    t_pipe_ctl             ctl;
    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] r_last;
    logic [IDX_BITS-1:0]   n_idx;
    logic                  n_last;
    t_wvec                 r_w;
    t_coord4               px;
    t_coord4               py;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_x <= RST_P1_X;
            r_p1_y <= RST_P1_Y;
            r_p2_x <= RST_P2_X;
            r_p2_y <= RST_P2_Y;
            r_p3_x <= RST_P3_X;
            r_p3_y <= RST_P3_Y;
            r_p4_x <= RST_P4_X;
            r_p4_y <= RST_P4_Y;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_P1_X: r_p1_x <= i_cfg_data;
                REG_P1_Y: r_p1_y <= i_cfg_data;
                REG_P2_X: r_p2_x <= i_cfg_data;
                REG_P2_Y: r_p2_y <= i_cfg_data;
                REG_P3_X: r_p3_x <= i_cfg_data;
                REG_P3_Y: r_p3_y <= i_cfg_data;
                REG_P4_X: r_p4_x <= i_cfg_data;
                REG_P4_Y: r_p4_y <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it loads too.
    always_comb begin
        ctl.en[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            ctl.en[k] = !r_valid[k] || ctl.en[k+1];
        end
    end

    assign o_stall = !ctl.en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (ctl.en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (ctl.en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign n_last = (i_sample_index >= IDX_BITS'(LAST_IDX));
    assign n_idx  = n_last ? IDX_BITS'(LAST_IDX) : i_sample_index;

    always_ff @(posedge i_clk) begin
        if (ctl.en[0]) begin
            r_w       <= W_TAB[n_idx];
            r_last[0] <= n_last;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (ctl.en[k]) begin
                r_last[k] <= r_last[k-1];
            end
        end
    end

    assign px = {r_p4_x, r_p3_x, r_p2_x, r_p1_x};
    assign py = {r_p4_y, r_p3_y, r_p2_y, r_p1_y};

    cfps_axis u_axis_x (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_w     (r_w),
        .i_p     (px),
        .o_point (o_point_x)
    );

    cfps_axis u_axis_y (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_w     (r_w),
        .i_p     (py),
        .o_point (o_point_y)
    );

    assign o_valid   = r_valid[NUM_STAGES-1];
    assign o_is_last = r_last[NUM_STAGES-1];

    `CFPS_ASSERT_IMPL(a_stall_only_when_full, i_clk, i_rst_n, o_stall, r_valid[NUM_STAGES-1] && i_stall)
    `CFPS_ASSERT_NEXT(a_accept_enters_pipe, i_clk, i_rst_n, i_valid && !o_stall, r_valid[0])
    `CFPS_ASSERT_NEXT(a_drain_moves_forward, i_clk, i_rst_n, r_valid[NUM_STAGES-2] && !i_stall, o_valid)

endmodule

`default_nettype wire

[src/cfps_axis.sv]
`default_nettype none

module cfps_axis (
    input  wire logic                i_clk,
    input  wire cfps_pkg::t_pipe_ctl i_ctl,
    input  wire cfps_pkg::t_wvec     i_w,
    input  wire cfps_pkg::t_coord4   i_p,
    output logic signed [cfps_pkg::COORD_BITS-1:0] o_point
);
    import cfps_pkg::*;

    logic signed [PROD_BITS-1:0] n_prod [4];
    logic signed [PROD_BITS-1:0] r_prod [4];
    logic signed [SUM_BITS-1:0]  n_sum;
    logic signed [SUM_BITS-1:0]  r_sum;

    logic [U_BITS-1:0]     r_u3;
    logic                  r_hi3;
    logic                  r_lo3;
    logic [QP_BITS-1:0]    n_qprod;
    logic [COORD_BITS-1:0] r_q0_4;
    logic [U_BITS-1:0]     r_u4;
    logic                  r_hi4;
    logic                  r_lo4;
    logic [U_BITS-1:0]     n_diff;
    logic [REM_BITS-1:0]   r_rem5;
    logic [COORD_BITS-1:0] r_q0_5;
    logic                  r_hi5;
    logic                  r_lo5;
    logic [COORD_BITS-1:0] n_q;
    logic [COORD_BITS-1:0] n_res;
    logic [COORD_BITS-1:0] r_res;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_prod[k] = $signed(i_p[k]) * $signed(i_w[k]);
        end
        n_sum = SUM_BITS'(r_prod[0]) + SUM_BITS'(r_prod[1]) + SUM_BITS'(r_prod[2])
              + SUM_BITS'(r_prod[3]) + SUM_BITS'(HALF_DEN);
    end

    // The quotient estimate from the reciprocal is low by at most two.
    assign n_qprod = QP_BITS'(r_u3[U_BITS-1 -: HI_BITS]) * QP_BITS'(RECIP);
    assign n_diff  = r_u4 - U_BITS'(r_q0_4) * U_BITS'(DEN);

    always_comb begin
        n_q = r_q0_5
            + COORD_BITS'(r_rem5 >= REM_BITS'(DEN))
            + COORD_BITS'(r_rem5 >= REM_BITS'(2 * DEN));
        n_res = {~n_q[COORD_BITS-1], n_q[COORD_BITS-2:0]};
        if (r_hi5) begin
            n_res = {1'b0, {(COORD_BITS-1){1'b1}}};
        end else if (r_lo5) begin
            n_res = {1'b1, {(COORD_BITS-1){1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[k] <= n_prod[k];
            end
        end
        if (i_ctl.en[2]) begin
            r_sum <= n_sum;
        end
        if (i_ctl.en[3]) begin
            r_hi3 <= (r_sum >= SAT_LIM);
            r_lo3 <= (r_sum < -SAT_LIM);
            r_u3  <= U_BITS'(r_sum + SAT_LIM);
        end
        if (i_ctl.en[4]) begin
            r_q0_4 <= n_qprod[HI_BITS +: COORD_BITS];
            r_u4   <= r_u3;
            r_hi4  <= r_hi3;
            r_lo4  <= r_lo3;
        end
        if (i_ctl.en[5]) begin
            r_rem5 <= n_diff[REM_BITS-1:0];
            r_q0_5 <= r_q0_4;
            r_hi5  <= r_hi4;
            r_lo5  <= r_lo4;
        end
        if (i_ctl.en[6]) begin
            r_res <= n_res;
        end
    end

    assign o_point = $signed(r_res);

endmodule

`default_nettype wire
